// File: hw/rtl/tgx_rle_pixel_decoder_macros.svh
// assertion macros for the run-length pixel decoder datapath
`ifndef TGX_RLE_PIXEL_DECODER_MACROS_SVH
`define TGX_RLE_PIXEL_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TRLE_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TRLE_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TRLE_ASSERT_IMP(label, ck, rn, ante, cons)

`define TRLE_ASSERT_NXT(label, ck, rn, ante, cons)

`endif

`endif

// File: hw/rtl/trle_pkg.sv
// shared constants, codes and control types of the run-length pixel decoder
`timescale 1ns / 1ps
`default_nettype none

package trle_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int BYTE_W     = 8;
    localparam int DIM_W      = 13;
    localparam int COL_W      = 16;
    localparam int IDX_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int RUN_W      = 6;
    localparam int PIX_W      = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // decode phase
    localparam logic [1:0] PH_HDR  = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    // token types from the header byte
    localparam logic [2:0] TOK_LITERAL = 3'd0;
    localparam logic [2:0] TOK_SKIP    = 3'd1;
    localparam logic [2:0] TOK_REPEAT  = 3'd2;
    localparam logic [2:0] TOK_NEWLINE = 3'd4;

    // frame status codes
    localparam logic [STATUS_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ERR_BAD_TYPE = 2'd1;
    localparam logic [STATUS_W-1:0] ERR_TRUNC    = 2'd2;
    localparam logic [STATUS_W-1:0] ERR_OUTSIDE  = 2'd3;

    // result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic accept;
        logic emit;
        logic status;
    } trle_cmd_t;

    typedef struct packed {
        logic will_emit;
        logic frame_end;
        logic emit_done;
        logic end_pend;
        logic out_free;
    } trle_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/trle_if.sv
// stream interfaces for coded bytes in and pixel or status results out
`timescale 1ns / 1ps
`default_nettype none

interface trle_byte_if import trle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              frame_start;
    logic              frame_end;

    modport source (output valid, output byte_value, output frame_start,
                    output frame_end, input ready);
    modport sink   (input valid, input byte_value, input frame_start,
                    input frame_end, output ready);
endinterface

interface trle_result_if import trle_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [IDX_W-1:0]    pixel_index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output result_kind, output pixel_index,
                    output red, output green, output blue, output status,
                    output last, input ready);
    modport sink   (input valid, input result_kind, input pixel_index,
                    input red, input green, input blue, input status,
                    input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/trle_datapath.sv
// decoder datapath: frame state, token decode, row base multiply, result register
`timescale 1ns / 1ps
`default_nettype none

`include "tgx_rle_pixel_decoder_macros.svh"

module trle_datapath import trle_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [BYTE_W-1:0]     byte_value,
    input  wire logic                  frame_start,
    input  wire logic                  frame_end,
    input  wire trle_cmd_t             cmd,
    output trle_stat_t                 stat,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic                       result_kind,
    output logic [IDX_W-1:0]           pixel_index,
    output logic [CHAN_W-1:0]          red,
    output logic [CHAN_W-1:0]          green,
    output logic [CHAN_W-1:0]          blue,
    output logic [STATUS_W-1:0]        status,
    output logic                       last
);

    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PROD_W = ROW_W + COL_W;

    logic [1:0]          phase_reg, phase_next;
    logic                rep_reg, rep_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic [BYTE_W-1:0]   low_reg, low_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [IDX_W-1:0]    rb_reg, rb_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [DIM_W-1:0]    w_reg, w_next;
    logic [DIM_W-1:0]    h_reg, h_next;
    logic [PIX_W-1:0]    pix_reg, pix_next;
    logic [RUN_W-1:0]    cnt_reg, cnt_next;
    logic                endp_reg, endp_next;
    logic                trunc_reg, trunc_next;

    logic                ovld_reg, ovld_next;
    logic                okind_reg, okind_next;
    logic [IDX_W-1:0]    oidx_reg, oidx_next;
    logic [CHAN_W-1:0]   ored_reg, ored_next;
    logic [CHAN_W-1:0]   ogrn_reg, ogrn_next;
    logic [CHAN_W-1:0]   oblu_reg, oblu_next;
    logic [STATUS_W-1:0] ost_reg, ost_next;
    logic                olast_reg, olast_next;

    logic [COL_W-1:0]    w_eff, h_eff;

    // decoded values for the byte at the input
    logic [1:0]          d_phase;
    logic                d_rep;
    logic [RUN_W-1:0]    d_run;
    logic [BYTE_W-1:0]   d_low;
    logic [COL_W-1:0]    d_col;
    logic [ROW_W-1:0]    d_row;
    logic [STATUS_W-1:0] d_err;
    logic [RUN_W-1:0]    d_cnt;
    logic                d_trunc;
    logic                d_rb_load;

    logic [1:0]          ph_s;
    logic                rep_s;
    logic [RUN_W-1:0]    run_s;
    logic [COL_W-1:0]    col_s;
    logic [ROW_W-1:0]    row_s;
    logic [STATUS_W-1:0] err_s;
    logic [2:0]          tok;
    logic [RUN_W-1:0]    len;
    logic [COL_W:0]      skip_sum;
    logic [RUN_W-1:0]    run_dec;
    logic [PROD_W-1:0]   prod;

    logic                out_free;
    logic                in_bounds;
    logic                emit_step;
    logic                status_load;
    logic [COL_W:0]      drop_sum;
    logic [STATUS_W-1:0] err_final;

    // effective image size: zero reads as one, clamp to the maximum
    always_comb
    begin
        if (w_reg == '0)
            w_eff = COL_W'(1);
        else if (32'(w_reg) > MAX_WIDTH)
            w_eff = COL_W'(MAX_WIDTH);
        else
            w_eff = COL_W'(w_reg);

        if (h_reg == '0)
            h_eff = COL_W'(1);
        else if (32'(h_reg) > MAX_HEIGHT)
            h_eff = COL_W'(MAX_HEIGHT);
        else
            h_eff = COL_W'(h_reg);
    end

    // token decode
    always_comb
    begin
        ph_s     = frame_start ? PH_HDR : phase_reg;
        rep_s    = frame_start ? 1'b0 : rep_reg;
        run_s    = frame_start ? '0 : run_reg;
        col_s    = frame_start ? '0 : col_reg;
        row_s    = frame_start ? ROW_W'(h_eff - COL_W'(1)) : row_reg;
        err_s    = frame_start ? ERR_NONE : err_reg;
        tok      = byte_value[7:5];
        len      = {1'b0, byte_value[4:0]} + RUN_W'(1);
        skip_sum = {1'b0, col_s} + (COL_W+1)'(len);
        run_dec  = (run_s != '0) ? run_s - RUN_W'(1) : '0;

        d_phase   = ph_s;
        d_rep     = rep_s;
        d_run     = run_s;
        d_low     = frame_start ? '0 : low_reg;
        d_col     = col_s;
        d_row     = row_s;
        d_err     = err_s;
        d_cnt     = '0;
        d_rb_load = frame_start;

        case (ph_s)
            PH_HDR:
            begin
                case (tok)
                    TOK_LITERAL, TOK_REPEAT:
                    begin
                        d_phase = PH_LOW;
                        d_rep   = (tok == TOK_REPEAT);
                        d_run   = len;
                    end
                    TOK_SKIP:
                    begin
                        d_col = skip_sum[COL_W] ? '1 : skip_sum[COL_W-1:0];
                    end
                    TOK_NEWLINE:
                    begin
                        d_col     = '0;
                        d_row     = (row_s != '0) ? row_s - ROW_W'(1) : row_s;
                        d_rb_load = 1'b1;
                    end
                    default:
                    begin
                        d_err   = (err_s == ERR_NONE) ? ERR_BAD_TYPE : err_s;
                        d_phase = PH_HALT;
                    end
                endcase
            end
            PH_LOW:
            begin
                d_low   = byte_value;
                d_phase = PH_HIGH;
            end
            PH_HIGH:
            begin
                if (rep_s)
                begin
                    d_cnt   = run_s;
                    d_run   = '0;
                    d_phase = PH_HDR;
                    d_rep   = 1'b0;
                end
                else
                begin
                    d_cnt   = RUN_W'(1);
                    d_run   = run_dec;
                    d_phase = (run_dec == '0) ? PH_HDR : PH_LOW;
                end
            end
            default:
            begin
            end
        endcase

        d_trunc = frame_end && (d_phase inside {PH_LOW, PH_HIGH});
        if (frame_end)
        begin
            d_phase = PH_HDR;
            d_rep   = 1'b0;
            d_run   = '0;
        end
    end

    // row base for the row after this byte
    assign prod = d_row * w_eff;

    assign out_free    = !ovld_reg || out_ready;
    assign emit_step   = cmd.emit && out_free;
    assign status_load = cmd.status && out_free;
    assign in_bounds   = (col_reg < w_eff) && (COL_W'(row_reg) < h_eff);
    assign drop_sum    = {1'b0, col_reg} + (COL_W+1)'(cnt_reg);
    assign err_final   = (err_reg != ERR_NONE) ? err_reg :
                         (trunc_reg ? ERR_TRUNC : ERR_NONE);

    always_comb
    begin
        phase_next = phase_reg;
        rep_next   = rep_reg;
        run_next   = run_reg;
        low_next   = low_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        rb_next    = rb_reg;
        err_next   = err_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        pix_next   = pix_reg;
        cnt_next   = cnt_reg;
        endp_next  = endp_reg;
        trunc_next = trunc_reg;

        okind_next = okind_reg;
        oidx_next  = oidx_reg;
        ored_next  = ored_reg;
        ogrn_next  = ogrn_reg;
        oblu_next  = oblu_reg;
        ost_next   = ost_reg;
        olast_next = olast_reg;
        ovld_next  = out_ready ? 1'b0 : ovld_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  w_next = cfg_data;
                REG_IMAGE_HEIGHT: h_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        if (cmd.accept)
        begin
            phase_next = d_phase;
            rep_next   = d_rep;
            run_next   = d_run;
            low_next   = d_low;
            col_next   = d_col;
            row_next   = d_row;
            err_next   = d_err;
            cnt_next   = d_cnt;
            pix_next   = {byte_value[6:0], low_reg};
            endp_next  = frame_end;
            trunc_next = d_trunc;
            if (d_rb_load)
                rb_next = IDX_W'(prod);
        end
        else if (emit_step)
        begin
            if (in_bounds)
            begin
                ovld_next  = 1'b1;
                okind_next = KIND_PIXEL;
                oidx_next  = rb_reg + IDX_W'(col_reg);
                ored_next  = {pix_reg[14:10], 3'b000};
                ogrn_next  = {pix_reg[9:5], 3'b000};
                oblu_next  = {pix_reg[4:0], 3'b000};
                ost_next   = ERR_NONE;
                // later writes of this run fall off the row
                olast_next = !endp_reg &&
                             (cnt_reg == RUN_W'(1) || col_reg == w_eff - COL_W'(1));
                col_next   = col_reg + COL_W'(1);
                cnt_next   = cnt_reg - RUN_W'(1);
            end
            else
            begin
                // rest of the run is outside: drop it in one go
                err_next = (err_reg == ERR_NONE) ? ERR_OUTSIDE : err_reg;
                col_next = drop_sum[COL_W] ? '1 : drop_sum[COL_W-1:0];
                cnt_next = '0;
            end
        end
        else if (status_load)
        begin
            ovld_next  = 1'b1;
            okind_next = KIND_STATUS;
            oidx_next  = '0;
            ored_next  = '0;
            ogrn_next  = '0;
            oblu_next  = '0;
            ost_next   = err_final;
            olast_next = 1'b1;
            err_next   = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            rep_reg   <= 1'b0;
            run_reg   <= '0;
            low_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            rb_reg    <= '0;
            err_reg   <= ERR_NONE;
            w_reg     <= DIM_W'(1);
            h_reg     <= DIM_W'(1);
            cnt_reg   <= '0;
            endp_reg  <= 1'b0;
            trunc_reg <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            rep_reg   <= rep_next;
            run_reg   <= run_next;
            low_reg   <= low_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            rb_reg    <= rb_next;
            err_reg   <= err_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            cnt_reg   <= cnt_next;
            endp_reg  <= endp_next;
            trunc_reg <= trunc_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg   <= pix_next;
        okind_reg <= okind_next;
        oidx_reg  <= oidx_next;
        ored_reg  <= ored_next;
        ogrn_reg  <= ogrn_next;
        oblu_reg  <= oblu_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

    assign stat.will_emit = (d_cnt != '0);
    assign stat.frame_end = frame_end;
    assign stat.emit_done = emit_step && (!in_bounds || cnt_reg == RUN_W'(1));
    assign stat.end_pend  = endp_reg;
    assign stat.out_free  = out_free;

    assign out_valid   = ovld_reg;
    assign result_kind = okind_reg;
    assign pixel_index = oidx_reg;
    assign red         = ored_reg;
    assign green       = ogrn_reg;
    assign blue        = oblu_reg;
    assign status      = ost_reg;
    assign last        = olast_reg;

    // a run in progress always has writes left
    `TRLE_ASSERT_IMP(a_emit_has_count, clk, rst_n, cmd.emit, cnt_reg != '0)
    // the frame error is cleared once its status is loaded
    `TRLE_ASSERT_NXT(a_err_cleared, clk, rst_n, status_load && !cmd.accept,
                     err_reg == ERR_NONE)
    // no pixel bytes are owed between tokens
    `TRLE_ASSERT_IMP(a_run_idle, clk, rst_n,
                     phase_reg == PH_HDR || phase_reg == PH_HALT, run_reg == '0)

endmodule

`default_nettype wire

// File: hw/rtl/trle_ctrl.sv
// decoder controller: byte acceptance, pixel run emission, frame status
`timescale 1ns / 1ps
`default_nettype none

module trle_ctrl import trle_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output trle_cmd_t       cmd,
    input  wire trle_stat_t stat
);

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_EMIT   = 2'd1;
    localparam logic [1:0] ST_STATUS = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_ACCEPT);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT:
            begin
                if (accept)
                begin
                    if (stat.will_emit)
                        state_next = ST_EMIT;
                    else if (stat.frame_end)
                        state_next = ST_STATUS;
                end
            end
            ST_EMIT:
            begin
                if (stat.emit_done)
                    state_next = stat.end_pend ? ST_STATUS : ST_ACCEPT;
            end
            ST_STATUS:
            begin
                if (stat.out_free)
                    state_next = ST_ACCEPT;
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACCEPT;
        else
            state_reg <= state_next;
    end

    assign cmd.accept = accept;
    assign cmd.emit   = (state_reg == ST_EMIT);
    assign cmd.status = (state_reg == ST_STATUS);

endmodule

`default_nettype wire

// File: hw/rtl/tgx_rle_pixel_decoder.sv
// top level of the run-length pixel decoder
// header and pixel low bytes are taken one per cycle unless they end a frame; a pixel high
// byte holds off new bytes until its writes (up to 32 for a repeat run) are loaded into the
// single result register or dropped; each write is loaded from the run count registered with
// the high byte; an outside run tail drops in one go, and a frame end adds a status beat
// reset clears the decode state and position and sets both image dimensions to one
`timescale 1ns / 1ps
`default_nettype none

module tgx_rle_pixel_decoder import trle_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    trle_byte_if.sink                  byte_in,
    trle_result_if.source              result_out
);

    trle_cmd_t  cmd;
    trle_stat_t stat;

    trle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_in.valid),
        .in_ready (byte_in.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    trle_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_value  (byte_in.byte_value),
        .frame_start (byte_in.frame_start),
        .frame_end   (byte_in.frame_end),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (result_out.ready),
        .out_valid   (result_out.valid),
        .result_kind (result_out.result_kind),
        .pixel_index (result_out.pixel_index),
        .red         (result_out.red),
        .green       (result_out.green),
        .blue        (result_out.blue),
        .status      (result_out.status),
        .last        (result_out.last)
    );

endmodule

`default_nettype wire

// File: sim/tgx_rle_pixel_decoder_tb.sv
// self-checking testbench for the run-length pixel decoder
`timescale 1ns / 1ps

module tgx_rle_pixel_decoder_tb;
    import trle_pkg::*;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int SETTLE_TICKS = 48;
    localparam int RANDOM_BYTES = 315;
    localparam int GEO_SETS     = 9;

    // header type that no token uses
    localparam logic [2:0] TOK_UNUSED = 3'd7;

    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    index;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [STATUS_W-1:0] status;
        logic                last;
    } beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              start;
        logic              stop;
    } coded_byte_t;

    class decode_scoreboard;
        logic [DIM_W-1:0]    width_reg;
        logic [DIM_W-1:0]    height_reg;
        logic [1:0]          phase;
        logic                repeating;
        logic [RUN_W-1:0]    run_left;
        logic [BYTE_W-1:0]   low_byte;
        logic [COL_W-1:0]    col;
        logic [11:0]         row;
        logic [IDX_W-1:0]    row_base;
        logic [STATUS_W-1:0] err;
        beat_t               awaited[$];
        int                  mismatches;

        function new();
            width_reg  = 1;
            height_reg = 1;
            phase      = PH_HDR;
            repeating  = 1'b0;
            run_left   = '0;
            low_byte   = '0;
            col        = '0;
            row        = '0;
            row_base   = '0;
            err        = ERR_NONE;
            mismatches = 0;
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h == 0) h = 1;
            if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
            return h;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = value;
            else
                height_reg = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void flag(logic [STATUS_W-1:0] code);
            if (err == ERR_NONE) err = code;
        endfunction

        function void place_pixel(logic [15:0] pix);
            beat_t b;
            if (col >= eff_width() || row >= eff_height())
                flag(ERR_OUTSIDE);
            else
            begin
                b       = '0;
                b.kind  = KIND_PIXEL;
                b.index = row_base + col;
                b.red   = {pix[14:10], 3'b000};
                b.green = {pix[9:5], 3'b000};
                b.blue  = {pix[4:0], 3'b000};
                awaited.push_back(b);
            end
            if (col != 16'hFFFF) col++;
        endfunction

        function void take_byte(coded_byte_t cb);
            int unsigned before_count;
            int unsigned run_len;
            int unsigned new_col;
            logic [2:0]  kind;
            beat_t       st;
            before_count = awaited.size();
            if (cb.start)
            begin
                phase     = PH_HDR;
                repeating = 1'b0;
                run_left  = '0;
                low_byte  = '0;
                err       = ERR_NONE;
                col       = '0;
                row       = 12'(eff_height() - 1);
                row_base  = IDX_W'(row * eff_width());
            end
            case (phase)
                PH_HDR:
                begin
                    kind    = cb.value[7:5];
                    run_len = cb.value[4:0] + 1;
                    if (kind == TOK_LITERAL || kind == TOK_REPEAT)
                    begin
                        phase     = PH_LOW;
                        repeating = (kind == TOK_REPEAT);
                        run_left  = RUN_W'(run_len);
                    end
                    else if (kind == TOK_SKIP)
                    begin
                        new_col = col + run_len;
                        col     = (new_col > 16'hFFFF) ? 16'hFFFF : COL_W'(new_col);
                    end
                    else if (kind == TOK_NEWLINE)
                    begin
                        col = '0;
                        if (row != 0) row--;
                        row_base = IDX_W'(row * eff_width());
                    end
                    else
                    begin
                        flag(ERR_BAD_TYPE);
                        phase = PH_HALT;
                    end
                end
                PH_LOW:
                begin
                    low_byte = cb.value;
                    phase    = PH_HIGH;
                end
                PH_HIGH:
                begin
                    if (repeating)
                    begin
                        while (run_left != 0)
                        begin
                            place_pixel({cb.value, low_byte});
                            run_left--;
                        end
                        phase = PH_HDR;
                    end
                    else
                    begin
                        place_pixel({cb.value, low_byte});
                        if (run_left != 0) run_left--;
                        phase = (run_left == 0) ? PH_HDR : PH_LOW;
                    end
                    if (phase == PH_HDR) repeating = 1'b0;
                end
                // halted: bytes are ignored until frame end or frame start
                default: ;
            endcase
            if (cb.stop)
            begin
                if (phase == PH_LOW || phase == PH_HIGH) flag(ERR_TRUNC);
                st        = '0;
                st.kind   = KIND_STATUS;
                st.status = err;
                awaited.push_back(st);
                phase     = PH_HDR;
                repeating = 1'b0;
                run_left  = '0;
                err       = ERR_NONE;
            end
            if (awaited.size() > before_count) awaited[awaited.size() - 1].last = 1'b1;
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void match_beat(beat_t got);
            beat_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, kind %0h index %0h status %0h",
                         $time, got.kind, got.index, got.status);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            check_field("result_kind", want.kind, got.kind);
            check_field("pixel_index", want.index, got.index);
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("status", want.status, got.status);
            check_field("last", want.last, got.last);
        endfunction

        function bit all_matched();
            if (awaited.size() != 0)
                $display("%0t: %0d expected result beats never arrived", $time, awaited.size());
            return mismatches == 0 && awaited.size() == 0;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           cycle_count = 0;
    int                    src_mode    = 0;
    int                    sink_mode   = 0;
    int unsigned           bytes_sent  = 0;
    decode_scoreboard      board;
    coded_byte_t           frame_q[$];

    int unsigned geo_w[8] = '{4, 1, 0, 4096, 8191, 5, 17, 64};
    int unsigned geo_h[8] = '{3, 1, 0, 4096, 8191, 4, 3, 2};

    trle_byte_if   byte_bus ();
    trle_result_if result_bus ();

    tgx_rle_pixel_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_in    (byte_bus),
        .result_out (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // mode 0 never waits, mode 1 waits now and then, mode 2 waits often
    function automatic int draw_wait(int mode);
        if (mode == 0) return 0;
        if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic coded_byte_t cb(logic [7:0] v, logic s = 1'b0, logic e = 1'b0);
        return {v, s, e};
    endfunction

    task automatic send_byte(coded_byte_t item);
        int gap;
        gap = draw_wait(src_mode);
        if (gap > 0)
        begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_bus.valid       <= 1'b1;
        byte_bus.byte_value  <= item.value;
        byte_bus.frame_start <= item.start;
        byte_bus.frame_end   <= item.stop;
        do
            @(posedge clk);
        while (!(byte_bus.valid === 1'b1 && byte_bus.ready === 1'b1));
        board.take_byte(item);
        bytes_sent++;
    endtask

    task automatic hold_for_results();
        byte_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // bytes that cause no beat may still be in flight after the last beat
    task automatic settle();
        hold_for_results();
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        board.set_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        board.set_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic build_frame();
        int         tokens;
        int         pick;
        int         len;
        int         cut;
        logic [2:0] kind;
        frame_q.delete();
        if ($urandom_range(0, 11) == 0)
        begin
            // noise, any token type
            repeat ($urandom_range(1, 8)) frame_q.push_back(cb(8'($urandom_range(0, 255))));
        end
        else
        begin
            tokens = $urandom_range(1, 6);
            repeat (tokens)
            begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 4);
                if (pick < 35)
                begin
                    frame_q.push_back(cb({TOK_LITERAL, 5'(len - 1)}));
                    repeat (2 * len) frame_q.push_back(cb(8'($urandom_range(0, 255))));
                end
                else if (pick < 60)
                begin
                    frame_q.push_back(cb({TOK_REPEAT, 5'(len - 1)}));
                    repeat (2) frame_q.push_back(cb(8'($urandom_range(0, 255))));
                end
                else if (pick < 75)
                    frame_q.push_back(cb({TOK_SKIP, 5'(len - 1)}));
                else if (pick < 95)
                    frame_q.push_back(cb({TOK_NEWLINE, 5'($urandom_range(0, 31))}));
                else
                begin
                    do
                        kind = 3'($urandom_range(0, 7));
                    while (kind == TOK_LITERAL || kind == TOK_SKIP ||
                           kind == TOK_REPEAT || kind == TOK_NEWLINE);
                    frame_q.push_back(cb({kind, 5'($urandom_range(0, 31))}));
                end
            end
            // chop the tail so the frame may end inside a token
            if ($urandom_range(0, 9) == 0 && frame_q.size() > 1)
            begin
                cut = $urandom_range(1, 2);
                repeat (cut)
                    if (frame_q.size() > 1) void'(frame_q.pop_back());
            end
        end
        // some frames run on from the previous position or stay open
        if ($urandom_range(0, 9) != 0) frame_q[0].start = 1'b1;
        if ($urandom_range(0, 9) != 0) frame_q[frame_q.size() - 1].stop = 1'b1;
    endtask

    task automatic run_directed();
        set_geometry(4, 3);
        // literal pair, skip, newlines down to the top row and past it
        send_byte(cb({TOK_LITERAL, 5'd1}, 1'b1, 1'b0));
        send_byte(cb(8'hFF));
        send_byte(cb(8'hFF));
        send_byte(cb(8'h00));
        send_byte(cb(8'h00));
        send_byte(cb({TOK_SKIP, 5'd1}));
        send_byte(cb({TOK_NEWLINE, 5'd0}));
        send_byte(cb({TOK_REPEAT, 5'd0}));
        send_byte(cb(8'h34));
        send_byte(cb(8'h12));
        send_byte(cb({TOK_NEWLINE, 5'd31}));
        send_byte(cb({TOK_NEWLINE, 5'd0}, 1'b0, 1'b1));
        // longest repeat run, most of it past the row end
        sink_mode = 2;
        send_byte(cb({TOK_REPEAT, 5'd31}, 1'b1, 1'b0));
        send_byte(cb(8'h1F));
        send_byte(cb(8'h7C));
        send_byte(cb({TOK_NEWLINE, 5'd0}, 1'b0, 1'b1));
        // unknown type halts, the rest of the frame is ignored
        src_mode = 2;
        send_byte(cb({TOK_UNUSED, 5'd0}, 1'b1, 1'b0));
        send_byte(cb(8'hAA));
        send_byte(cb({TOK_LITERAL, 5'd0}, 1'b0, 1'b1));
        // frame ends between pixel bytes
        send_byte(cb({TOK_LITERAL, 5'd0}, 1'b1, 1'b0));
        send_byte(cb(8'h12, 1'b0, 1'b1));
        send_byte(cb({TOK_NEWLINE, 5'd0}, 1'b1, 1'b1));
        // width change mid-frame keeps the old row base
        send_byte(cb({TOK_LITERAL, 5'd0}, 1'b1, 1'b0));
        settle();
        set_geometry(7, 3);
        send_byte(cb(8'h34));
        send_byte(cb(8'h12, 1'b0, 1'b1));
        settle();
    endtask

    initial
    begin
        int    stall;
        beat_t got;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(sink_mode);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_bus.valid === 1'b1 && result_bus.ready === 1'b1));
            got.kind   = result_bus.result_kind;
            got.index  = result_bus.pixel_index;
            got.red    = result_bus.red;
            got.green  = result_bus.green;
            got.blue   = result_bus.blue;
            got.status = result_bus.status;
            got.last   = result_bus.last;
            board.match_beat(got);
        end
    end

    initial
    begin
        int unsigned target;
        board = new();
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_IMAGE_WIDTH;
        cfg_data             <= '0;
        byte_bus.valid       <= 1'b0;
        byte_bus.byte_value  <= '0;
        byte_bus.frame_start <= 1'b0;
        byte_bus.frame_end   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < GEO_SETS; p++)
        begin
            if (p < 8)
                set_geometry(geo_w[p], geo_h[p]);
            else
                set_geometry($urandom_range(1, 40), $urandom_range(1, 40));
            target = bytes_sent + RANDOM_BYTES / GEO_SETS;
            while (bytes_sent < target)
            begin
                src_mode  = $urandom_range(0, 2);
                sink_mode = $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0) hold_for_results();
                build_frame();
                foreach (frame_q[i]) send_byte(frame_q[i]);
            end
            settle();
        end

        if (board.all_matched())
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
